// ===== rtl/lru_key_value_cache_assert.svh =====
// Assertion macros for the LRU key-value cache.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

`ifndef SYNTH
`define LKVC_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("lkvc assertion failed");
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lkvc assertion failed");
`else
`define LKVC_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/lkvc_pkg.sv =====
// Shared constants and types for the LRU key-value cache.
package lkvc_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int CAP_BITS   = 5;
    localparam int IDX_BITS   = $clog2(ENTRIES);
    localparam int RANK_BITS  = $clog2(ENTRIES);
    localparam int CNT_BITS   = $clog2(ENTRIES + 1);
    localparam int CAP_RESET  = 16;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_SET = 1'b1;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic update;
        logic load_out;
    } t_dp_cmd;

endpackage

// ===== rtl/lkvc_ctrl.sv =====
// Request sequencer: accept, lookup, update, result hand-off.
module lkvc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output lkvc_pkg::t_dp_cmd o_cmd
);
    import lkvc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_UPDATE,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   load;

    assign load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: n_state = S_UPDATE;
            S_UPDATE: n_state = S_DONE;
            S_DONE: begin
                if (load) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_cmd.capture  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.lookup   = (r_state == S_LOOKUP);
    assign o_cmd.update   = (r_state == S_UPDATE);
    assign o_cmd.load_out = load;

endmodule

// ===== rtl/lkvc_datapath.sv =====
// Entry store, parallel tag compare, recency ranks and result register.
`include "lru_key_value_cache_assert.svh"

module lkvc_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lkvc_pkg::t_dp_cmd                 i_cmd,
    input  logic [lkvc_pkg::CAP_BITS-1:0]     i_capacity,
    input  logic                              i_action,
    input  logic [lkvc_pkg::KEY_BITS-1:0]     i_key,
    input  logic [lkvc_pkg::VALUE_BITS-1:0]   i_value,
    output logic                              o_hit,
    output logic [lkvc_pkg::VALUE_BITS-1:0]   o_read_value,
    output logic                              o_evicted
);
    import lkvc_pkg::*;

    localparam int CMP_BITS = (CAP_BITS > CNT_BITS) ? CAP_BITS : CNT_BITS;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_HIT,
        OP_FILL,
        OP_EVICT
    } t_op;

    logic                  r_action;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;

    logic [KEY_BITS-1:0]   r_keys [ENTRIES];
    logic [VALUE_BITS-1:0] r_mem  [ENTRIES];
    logic [ENTRIES-1:0]    r_valid;
    logic [RANK_BITS-1:0]  r_rank [ENTRIES];
    logic [CNT_BITS-1:0]   r_used;

    t_op                   r_op;
    t_op                   n_op;
    logic [IDX_BITS-1:0]   r_sel;
    logic [IDX_BITS-1:0]   n_sel;
    logic [RANK_BITS-1:0]  r_old_rank;
    logic [RANK_BITS-1:0]  n_old_rank;
    logic [VALUE_BITS-1:0] r_rd_data;

    logic                  r_hit;
    logic [VALUE_BITS-1:0] r_read_value;
    logic                  r_evicted;

    logic [ENTRIES-1:0]    match;
    logic [ENTRIES-1:0]    victim;
    logic [IDX_BITS-1:0]   hit_idx;
    logic [IDX_BITS-1:0]   free_idx;
    logic [IDX_BITS-1:0]   vic_idx;
    logic [RANK_BITS-1:0]  last_rank;
    logic [CMP_BITS-1:0]   cap_x;
    logic [CMP_BITS-1:0]   eff_cap;
    logic                  can_fill;

    assign last_rank = RANK_BITS'(r_used - CNT_BITS'(1));

    always_comb begin
        cap_x = CMP_BITS'(i_capacity);
        if (cap_x == '0) begin
            eff_cap = CMP_BITS'(1);
        end else if (cap_x > CMP_BITS'(ENTRIES)) begin
            eff_cap = CMP_BITS'(ENTRIES);
        end else begin
            eff_cap = cap_x;
        end
        can_fill = CMP_BITS'(r_used) < eff_cap;
    end

    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        vic_idx  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]  = r_valid[i] && (r_keys[i] == r_key);
            victim[i] = r_valid[i] && (r_rank[i] == last_rank);
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = IDX_BITS'(i);
            end
            if (!r_valid[i]) begin
                free_idx = IDX_BITS'(i);
            end
            if (victim[i]) begin
                vic_idx = IDX_BITS'(i);
            end
        end
    end

    always_comb begin
        n_op       = OP_NONE;
        n_sel      = hit_idx;
        n_old_rank = r_rank[hit_idx];
        if (match != '0) begin
            n_op = OP_HIT;
        end else if (r_action == ACT_SET) begin
            if (can_fill) begin
                n_op       = OP_FILL;
                n_sel      = free_idx;
                n_old_rank = RANK_BITS'(r_used);
            end else if (r_used != '0) begin
                n_op       = OP_EVICT;
                n_sel      = vic_idx;
                n_old_rank = last_rank;
            end
        end
    end

    // control state: valid bits, ranks, fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_used  <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cmd.update && (r_op != OP_NONE)) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (IDX_BITS'(i) == r_sel) begin
                    r_rank[i] <= '0;
                end else if (r_valid[i] && (r_rank[i] < r_old_rank)) begin
                    r_rank[i] <= r_rank[i] + RANK_BITS'(1);
                end
            end
            if (r_op == OP_FILL) begin
                r_valid[r_sel] <= 1'b1;
                r_used         <= r_used + CNT_BITS'(1);
            end
        end
    end

    // payload: request, entry contents, decision, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_key    <= i_key;
            r_value  <= i_value;
        end
        if (i_cmd.lookup) begin
            r_op       <= n_op;
            r_sel      <= n_sel;
            r_old_rank <= n_old_rank;
        end
        if (i_cmd.update) begin
            r_rd_data <= r_mem[r_sel];
            case (r_op) inside
                OP_HIT: begin
                    if (r_action == ACT_SET) begin
                        r_mem[r_sel] <= r_value;
                    end
                end
                OP_FILL, OP_EVICT: begin
                    r_keys[r_sel] <= r_key;
                    r_mem[r_sel]  <= r_value;
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.load_out) begin
            r_hit        <= (r_op == OP_HIT);
            r_read_value <= ((r_op == OP_HIT) && (r_action == ACT_GET)) ? r_rd_data : '0;
            r_evicted    <= (r_op == OP_EVICT);
        end
    end

    assign o_hit        = r_hit;
    assign o_read_value = r_read_value;
    assign o_evicted    = r_evicted;

    `LKVC_ASSERT_ALWAYS(a_used_max, i_clk, i_rst_n, r_used <= CNT_BITS'(ENTRIES))
    `LKVC_ASSERT_ALWAYS(a_used_valid, i_clk, i_rst_n, $countones(r_valid) == int'(r_used))
    `LKVC_ASSERT_ALWAYS(a_one_match, i_clk, i_rst_n, !i_cmd.lookup || $onehot0(match))
    `LKVC_ASSERT_ALWAYS(a_one_victim, i_clk, i_rst_n,
        !(i_cmd.lookup && (r_used != '0)) || $onehot(victim))
    `LKVC_ASSERT_NEXT(a_fill_grows, i_clk, i_rst_n, i_cmd.update && (r_op == OP_FILL),
        r_used == $past(r_used) + CNT_BITS'(1))

endmodule

// ===== rtl/lru_key_value_cache.sv =====
// Top level of the LRU key-value cache: config register, sequencer, datapath.
//
//  channel   valid        stall        payload
//  request   i_in_valid   o_in_stall   i_action, i_key, i_value
//  result    o_out_valid  i_out_stall  o_hit, o_read_value, o_evicted
//  config    APB          pready = 1   capacity at byte address 0
//
// A request runs through accept, tag compare and victim pick, entry and
// rank update and result load; the next request is taken in the cycle after.
// The result register holds one result; a stalled result holds the
// sequencer in its last step until taken.
// Reset clears valid bits, ranks and fill count at once; no clearing pass.
module lru_key_value_cache (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_action,
    input  logic [lkvc_pkg::KEY_BITS-1:0]     i_key,
    input  logic [lkvc_pkg::VALUE_BITS-1:0]   i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_hit,
    output logic [lkvc_pkg::VALUE_BITS-1:0]   o_read_value,
    output logic                              o_evicted,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import lkvc_pkg::*;

    logic [CAP_BITS-1:0] r_capacity;
    t_dp_cmd             cmd;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(32 - CAP_BITS){1'b0}}, r_capacity} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_BITS'(CAP_RESET);
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_capacity <= pwdata[CAP_BITS-1:0];
        end
    end

    lkvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    lkvc_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_capacity   (r_capacity),
        .i_action     (i_action),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_hit        (o_hit),
        .o_read_value (o_read_value),
        .o_evicted    (o_evicted)
    );

endmodule
